// File: src/cbsa_pkg.sv
// Shared types, constants and control bundles of the complex band statistics accumulator.
`timescale 1ns / 1ps
package cbsa_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int MAX_BANDS = 64;

   localparam int KIND_W   = 2;
   localparam int SLOT_W   = 6;
   localparam int IDX_W    = 8;
   localparam int VAL_W    = 16;
   localparam int FC_W     = 7;
   localparam int VL_W     = 9;
   localparam int STRIDE_W = 16;
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 16;
   localparam int SUM_W    = 48;
   localparam int CNT_W    = 32;
   localparam int MAG_W    = 16;
   localparam int CONC_W   = 17;
   localparam int SQ_W     = 32;
   localparam int ROOT_W   = 16;
   localparam int DVD_W    = SUM_W + 1;
   localparam int DVS_W    = CNT_W;
   localparam int STEP_W   = $clog2(DVD_W + 1);

   localparam int ACC_DEPTH = MAX_SLOTS * MAX_BANDS;
   localparam int ACC_AW    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
   localparam int SLOT_AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int BAND_AW   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

   localparam logic [FC_W-1:0]     FC_RESET     = FC_W'(64);
   localparam logic [VL_W-1:0]     VL_RESET     = VL_W'(128);
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1);

   typedef enum logic [KIND_W-1:0] {
      KIND_ELEM  = 2'd0,
      KIND_BATCH = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_FREQ_COUNT    = 2'd0,
      CSR_VECTOR_LENGTH = 2'd1,
      CSR_PAIRING_STYLE = 2'd2,
      CSR_BATCH_STRIDE  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_RE   = 2'd0,
      DIV_IM   = 2'd1,
      DIV_MAG  = 2'd2,
      DIV_CONC = 2'd3
   } div_sel_type;

   typedef enum logic [14:0] {
      S_CLEAR   = 15'b000000000000001,
      S_IDLE    = 15'b000000000000010,
      S_E_RD    = 15'b000000000000100,
      S_E_MUL   = 15'b000000000001000,
      S_E_SQRT  = 15'b000000000010000,
      S_E_WAIT  = 15'b000000000100000,
      S_E_WR    = 15'b000000001000000,
      S_R_RD    = 15'b000000010000000,
      S_R_DATA  = 15'b000000100000000,
      S_R_DSTART= 15'b000001000000000,
      S_R_DWAIT = 15'b000010000000000,
      S_R_MUL   = 15'b000100000000000,
      S_R_SQRT  = 15'b001000000000000,
      S_R_SWAIT = 15'b010000000000000,
      S_R_OUT   = 15'b100000000000000
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        batch;
      logic        clear_we;
      logic        mem_rd;
      logic        mul;
      logic        mul_ro;
      logic        sqrt_start;
      logic        div_start;
      div_sel_type div_sel;
      logic        div_take;
      logic        am_take;
      logic        stats_clear;
      logic        elem_wr;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic elem_ok;
      logic ro_zero;
      logic mm_zero;
      logic sqrt_idle;
      logic div_idle;
      logic rsp_free;
   } status_type;

endpackage

// File: src/cbsa_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module cbsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// File: src/cbsa_isqrt.sv
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module cbsa_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cbsa_pkg::SQ_W-1:0]  value,
   output logic                       busy,
   output logic [cbsa_pkg::ROOT_W-1:0] root
);
   import cbsa_pkg::*;

   logic [SQ_W-1:0] v_ff, r_ff, bit_ff;
   logic [SQ_W-1:0] trial;

   assign trial = r_ff + bit_ff;
   assign busy  = |bit_ff;
   assign root  = r_ff[ROOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else if (start) begin
         bit_ff <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy) begin
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff <= value;
         r_ff <= '0;
      end else if (busy) begin
         if (v_ff >= trial) begin
            v_ff <= v_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
      end
   end
endmodule

// File: src/cbsa_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module cbsa_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cbsa_pkg::DVD_W-1:0] dividend,
   input  logic [cbsa_pkg::DVS_W-1:0] divisor,
   output logic                       busy,
   output logic [cbsa_pkg::DVD_W-1:0] quotient
);
   import cbsa_pkg::*;

   logic [DVS_W-1:0]  rem_ff, dvs_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DVS_W:0]    trial;
   logic              fits;

   assign trial    = {rem_ff, quo_ff[DVD_W-1]};
   assign fits     = trial >= {1'b0, dvs_ff};
   assign busy     = step_ff != '0;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (start) begin
         step_ff <= STEP_W'(DVD_W);
      end else if (busy) begin
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy) begin
         rem_ff <= fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
      end
   end
endmodule

// File: src/cbsa_datapath.sv
// Datapath: configuration, accumulator memories, arithmetic units and result word.
`timescale 1ns / 1ps
module cbsa_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  cbsa_pkg::cmd_type             cmd,
   output cbsa_pkg::status_type          status,
   input  logic [cbsa_pkg::KIND_W-1:0]   req_kind,
   input  logic [cbsa_pkg::SLOT_W-1:0]   req_slot,
   input  logic [cbsa_pkg::IDX_W-1:0]    req_element_index,
   input  logic signed [cbsa_pkg::VAL_W-1:0] req_element_value,
   input  logic                          csr_wr_en,
   input  logic [cbsa_pkg::CSR_IW-1:0]   csr_index,
   input  logic [cbsa_pkg::CSR_DW-1:0]   csr_data,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic signed [cbsa_pkg::VAL_W-1:0] rsp_mean_real,
   output logic signed [cbsa_pkg::VAL_W-1:0] rsp_mean_imag,
   output logic [cbsa_pkg::MAG_W-1:0]    rsp_mean_magnitude,
   output logic [cbsa_pkg::CONC_W-1:0]   rsp_concentration,
   output logic [cbsa_pkg::CNT_W-1:0]    rsp_sample_count
);
   import cbsa_pkg::*;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // configuration and batch state
   logic [FC_W-1:0]     fc_ff;
   logic [VL_W-1:0]     vl_ff;
   logic                style_ff;
   logic [STRIDE_W-1:0] stride_ff, phase_ff, phase_in;
   logic                collect_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff     <= FC_RESET;
         vl_ff     <= VL_RESET;
         style_ff  <= 1'b0;
         stride_ff <= STRIDE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FREQ_COUNT:    fc_ff     <= csr_data[FC_W-1:0];
            CSR_VECTOR_LENGTH: vl_ff     <= csr_data[VL_W-1:0];
            CSR_PAIRING_STYLE: style_ff  <= csr_data[0];
            CSR_BATCH_STRIDE:  stride_ff <= csr_data[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff + STRIDE_W'(1);
      if (stride_ff > STRIDE_W'(1) && phase_in >= stride_ff) begin
         phase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         collect_ff <= 1'b0;
      end else if (cmd.batch) begin
         phase_ff   <= phase_in;
         collect_ff <= stride_ff <= STRIDE_W'(1) || phase_in == '0;
      end
   end

   // captured request word
   logic                    ro_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic signed [VAL_W-1:0] val_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ro_ff   <= kind_type'(req_kind) == KIND_READ;
         slot_ff <= req_slot;
         idx_ff  <= req_element_index;
         val_ff  <= req_element_value;
      end
   end

   // element decode
   logic [VL_W-1:0]  idx9, fc9;
   logic [IDX_W-1:0] band, sel_band;
   logic             second, pair_ok, band_ok, vec_end, ro_band_ok, slot_ok;
   logic [ACC_AW-1:0] acc_addr;

   always_comb begin
      idx9 = VL_W'(idx_ff);
      fc9  = VL_W'(fc_ff);
      pair_ok = idx9 < {fc9[VL_W-2:0], 1'b0} && idx9 < vl_ff;
      if (style_ff) begin
         second = idx_ff[0];
         band   = idx_ff >> 1;
      end else begin
         second = idx9 >= fc9;
         band   = second ? IDX_W'(idx9 - fc9) : idx_ff;
      end
      band_ok    = int'(band) < MAX_BANDS;
      vec_end    = idx9 + VL_W'(1) == vl_ff;
      ro_band_ok = idx9 < fc9 && int'(idx_ff) < MAX_BANDS;
      slot_ok    = int'(slot_ff) < MAX_SLOTS;
      sel_band   = ro_ff ? idx_ff : band;
      acc_addr   = ACC_AW'(int'(slot_ff) * MAX_BANDS + int'(sel_band));
   end

   // memories
   logic [ACC_AW-1:0]  clr_cnt_ff;
   logic               sum_we, cnt_we, pend_we;
   logic [ACC_AW-1:0]  sum_waddr;
   logic [SUM_W-1:0]   re_wd, im_wd, mag_wd, re_q, im_q, mag_q;
   logic [SLOT_AW-1:0] cnt_waddr;
   logic [CNT_W-1:0]   cnt_wd, cnt_q, cnt_eff;
   logic [VAL_W-1:0]   pend_q;
   logic [ROOT_W-1:0]  root;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_we) begin
         clr_cnt_ff <= clr_cnt_ff + ACC_AW'(1);
      end
   end

   logic signed [SUM_W:0] re_s, im_s;
   logic [SUM_W:0]        mag_s;

   always_comb begin
      re_s  = {re_q[SUM_W-1], re_q} + (SUM_W+1)'($signed(pend_q));
      im_s  = {im_q[SUM_W-1], im_q} + (SUM_W+1)'(val_ff);
      mag_s = {1'b0, mag_q} + (SUM_W+1)'(root);
      sum_we    = cmd.clear_we || (cmd.elem_wr && second && pair_ok && band_ok);
      pend_we   = cmd.elem_wr && !second && pair_ok && band_ok;
      cnt_we    = (cmd.clear_we && int'(clr_cnt_ff) < MAX_SLOTS)
                  || (cmd.elem_wr && vec_end && cnt_q != '1);
      sum_waddr = cmd.clear_we ? clr_cnt_ff : acc_addr;
      cnt_waddr = cmd.clear_we ? SLOT_AW'(clr_cnt_ff) : SLOT_AW'(slot_ff);
      if (cmd.clear_we) begin
         re_wd  = '0;
         im_wd  = '0;
         mag_wd = '0;
         cnt_wd = '0;
      end else begin
         re_wd  = (re_s[SUM_W] != re_s[SUM_W-1]) ? (re_s[SUM_W] ? SUM_MIN : SUM_MAX)
                                                 : re_s[SUM_W-1:0];
         im_wd  = (im_s[SUM_W] != im_s[SUM_W-1]) ? (im_s[SUM_W] ? SUM_MIN : SUM_MAX)
                                                 : im_s[SUM_W-1:0];
         mag_wd = mag_s[SUM_W] ? '1 : mag_s[SUM_W-1:0];
         cnt_wd = cnt_q + CNT_W'(1);
      end
   end

   cbsa_ram #(.WIDTH(SUM_W), .DEPTH(ACC_DEPTH)) u_re_ram (
      .clock(clock), .wr_en(sum_we), .wr_addr(sum_waddr), .wr_data(re_wd),
      .rd_en(cmd.mem_rd), .rd_addr(acc_addr), .rd_data(re_q));
   cbsa_ram #(.WIDTH(SUM_W), .DEPTH(ACC_DEPTH)) u_im_ram (
      .clock(clock), .wr_en(sum_we), .wr_addr(sum_waddr), .wr_data(im_wd),
      .rd_en(cmd.mem_rd), .rd_addr(acc_addr), .rd_data(im_q));
   cbsa_ram #(.WIDTH(SUM_W), .DEPTH(ACC_DEPTH)) u_mag_ram (
      .clock(clock), .wr_en(sum_we), .wr_addr(sum_waddr), .wr_data(mag_wd),
      .rd_en(cmd.mem_rd), .rd_addr(acc_addr), .rd_data(mag_q));
   cbsa_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SLOTS)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wd),
      .rd_en(cmd.mem_rd), .rd_addr(SLOT_AW'(slot_ff)), .rd_data(cnt_q));
   cbsa_ram #(.WIDTH(VAL_W), .DEPTH(MAX_BANDS)) u_pend_ram (
      .clock(clock), .wr_en(pend_we), .wr_addr(BAND_AW'(band)), .wr_data(val_ff),
      .rd_en(cmd.mem_rd), .rd_addr(BAND_AW'(band)), .rd_data(pend_q));

   // squares and square root
   logic signed [VAL_W-1:0] mr_ff, mi_ff, opa, opb;
   logic [SQ_W-1:0]         sq_a_ff, sq_b_ff;
   logic signed [SQ_W-1:0]  prod_a, prod_b;
   logic                    sqrt_busy;

   assign opa    = cmd.mul_ro ? mr_ff : $signed(pend_q);
   assign opb    = cmd.mul_ro ? mi_ff : val_ff;
   assign prod_a = opa * opa;
   assign prod_b = opb * opb;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         sq_a_ff <= prod_a;
         sq_b_ff <= prod_b;
      end
   end

   cbsa_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(cmd.sqrt_start),
      .value(sq_a_ff + sq_b_ff), .busy(sqrt_busy), .root(root));

   // readout divisions
   logic [SUM_W-1:0]  abs_re, abs_im;
   logic [DVD_W-1:0]  dvd, quo;
   logic [DVS_W-1:0]  dvs;
   logic              div_busy;
   logic [MAG_W-1:0]  mm_ff;
   logic [ROOT_W-1:0] am_ff;
   logic [CONC_W-1:0] conc_ff;
   logic              neg;

   assign cnt_eff = slot_ok ? cnt_q : '0;
   assign abs_re  = re_q[SUM_W-1] ? SUM_W'(-re_q) : re_q;
   assign abs_im  = im_q[SUM_W-1] ? SUM_W'(-im_q) : im_q;

   always_comb begin
      dvs = cnt_eff;
      unique case (cmd.div_sel)
         DIV_RE:   dvd = DVD_W'(abs_re) + DVD_W'(cnt_eff >> 1);
         DIV_IM:   dvd = DVD_W'(abs_im) + DVD_W'(cnt_eff >> 1);
         DIV_MAG:  dvd = DVD_W'(mag_q) + DVD_W'(cnt_eff >> 1);
         DIV_CONC: begin
            dvd = DVD_W'({am_ff, 16'h0000});
            dvs = DVS_W'(mm_ff);
         end
         default:  dvd = '0;
      endcase
      neg = (cmd.div_sel == DIV_RE) ? re_q[SUM_W-1] : im_q[SUM_W-1];
   end

   cbsa_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(dvd), .divisor(dvs), .busy(div_busy), .quotient(quo));

   logic signed [VAL_W-1:0] mean_s;

   always_comb begin
      if (neg) begin
         mean_s = (quo > DVD_W'(32768)) ? VAL_W'(-32768) : VAL_W'(-quo);
      end else begin
         mean_s = (quo > DVD_W'(32767)) ? VAL_W'(32767) : VAL_W'(quo);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.stats_clear) begin
         mr_ff   <= '0;
         mi_ff   <= '0;
         mm_ff   <= '0;
         conc_ff <= '0;
      end else if (cmd.div_take) begin
         unique case (cmd.div_sel)
            DIV_RE:   mr_ff <= mean_s;
            DIV_IM:   mi_ff <= mean_s;
            DIV_MAG:  mm_ff <= (quo > DVD_W'(65535)) ? '1 : quo[MAG_W-1:0];
            DIV_CONC: conc_ff <= (quo > DVD_W'(65536)) ? CONC_W'(65536) : quo[CONC_W-1:0];
            default: ;
         endcase
      end
      if (cmd.am_take) begin
         am_ff <= root;
      end
   end

   // result word
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_mean_real      <= mr_ff;
         rsp_mean_imag      <= mi_ff;
         rsp_mean_magnitude <= mm_ff;
         rsp_concentration  <= conc_ff;
         rsp_sample_count   <= cnt_eff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      status.clear_last = clr_cnt_ff == ACC_AW'(ACC_DEPTH - 1);
      status.elem_ok    = collect_ff && int'(req_slot) < MAX_SLOTS;
      status.ro_zero    = cnt_eff == '0 || !ro_band_ok;
      status.mm_zero    = mm_ff == '0;
      status.sqrt_idle  = !sqrt_busy;
      status.div_idle   = !div_busy;
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end
endmodule

// File: src/cbsa_ctrl.sv
// Controller state machine: clearing pass, element update and readout sequencing.
`timescale 1ns / 1ps
module cbsa_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [cbsa_pkg::KIND_W-1:0] req_kind,
   output logic                        req_stall,
   input  cbsa_pkg::status_type        status,
   output cbsa_pkg::cmd_type           cmd
);
   import cbsa_pkg::*;

   state_type   state_ff, state_in;
   div_sel_type sel_ff, sel_in;
   logic        accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in    = state_ff;
      sel_in      = sel_ff;
      cmd         = '0;
      cmd.div_sel = sel_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_we = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.capture = accept;
            cmd.batch   = accept && kind_type'(req_kind) == KIND_BATCH;
            if (accept) begin
               if (kind_type'(req_kind) == KIND_ELEM && status.elem_ok) begin
                  state_in = S_E_RD;
               end else if (kind_type'(req_kind) == KIND_READ) begin
                  state_in = S_R_RD;
               end
            end
         end
         S_E_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_E_MUL;
         end
         S_E_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_E_SQRT;
         end
         S_E_SQRT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_E_WAIT;
         end
         S_E_WAIT: begin
            if (status.sqrt_idle) state_in = S_E_WR;
         end
         S_E_WR: begin
            cmd.elem_wr = 1'b1;
            state_in    = S_IDLE;
         end
         S_R_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_R_DATA;
         end
         S_R_DATA: begin
            cmd.stats_clear = 1'b1;
            sel_in          = DIV_RE;
            state_in        = status.ro_zero ? S_R_OUT : S_R_DSTART;
         end
         S_R_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_R_DWAIT;
         end
         S_R_DWAIT: begin
            if (status.div_idle) begin
               cmd.div_take = 1'b1;
               unique case (sel_ff)
                  DIV_RE: begin
                     sel_in   = DIV_IM;
                     state_in = S_R_DSTART;
                  end
                  DIV_IM: begin
                     sel_in   = DIV_MAG;
                     state_in = S_R_DSTART;
                  end
                  DIV_MAG:  state_in = S_R_MUL;
                  DIV_CONC: state_in = S_R_OUT;
                  default:  state_in = S_R_OUT;
               endcase
            end
         end
         S_R_MUL: begin
            cmd.mul    = 1'b1;
            cmd.mul_ro = 1'b1;
            state_in   = S_R_SQRT;
         end
         S_R_SQRT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_R_SWAIT;
         end
         S_R_SWAIT: begin
            if (status.sqrt_idle) begin
               cmd.am_take = 1'b1;
               if (status.mm_zero) begin
                  state_in = S_R_OUT;
               end else begin
                  sel_in   = DIV_CONC;
                  state_in = S_R_DSTART;
               end
            end
         end
         S_R_OUT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sel_ff   <= DIV_RE;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free) else $error("result word overwritten");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> status.div_idle) else $error("divider restarted while busy");
   a_sqrt_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_start |-> status.sqrt_idle) else $error("square root restarted while busy");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_we |-> !cmd.elem_wr && !cmd.capture) else $error("update during clear");
endmodule

// File: src/complex_band_statistics_accumulator_top.sv
// Top level of the complex band statistics accumulator.
// After reset a clearing pass over all MAX_SLOTS*MAX_BANDS (4096) entries zeroes the accumulators;
// req_stall stays high meanwhile. Batch marks and unused kinds are taken without leaving idle.
// An element runs through memory read, squaring, 16-step square root and write-back.
// A readout uses the bit-serial 49-step divider for the three means and the
// concentration; with no samples it skips the divisions.
`timescale 1ns / 1ps
module complex_band_statistics_accumulator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cbsa_pkg::KIND_W-1:0]   req_kind,
   input  logic [cbsa_pkg::SLOT_W-1:0]   req_slot,
   input  logic [cbsa_pkg::IDX_W-1:0]    req_element_index,
   input  logic signed [cbsa_pkg::VAL_W-1:0] req_element_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [cbsa_pkg::VAL_W-1:0] rsp_mean_real,
   output logic signed [cbsa_pkg::VAL_W-1:0] rsp_mean_imag,
   output logic [cbsa_pkg::MAG_W-1:0]    rsp_mean_magnitude,
   output logic [cbsa_pkg::CONC_W-1:0]   rsp_concentration,
   output logic [cbsa_pkg::CNT_W-1:0]    rsp_sample_count,
   input  logic                          csr_wr_en,
   input  logic [cbsa_pkg::CSR_IW-1:0]   csr_index,
   input  logic [cbsa_pkg::CSR_DW-1:0]   csr_data
);
   import cbsa_pkg::*;

   cmd_type    cmd;
   status_type status;

   cbsa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_kind(req_kind),
      .req_stall(req_stall), .status(status), .cmd(cmd));

   cbsa_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_kind(req_kind), .req_slot(req_slot), .req_element_index(req_element_index),
      .req_element_value(req_element_value),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid),
      .rsp_mean_real(rsp_mean_real), .rsp_mean_imag(rsp_mean_imag),
      .rsp_mean_magnitude(rsp_mean_magnitude), .rsp_concentration(rsp_concentration),
      .rsp_sample_count(rsp_sample_count));
endmodule
